FILE: src/eot_pkg.sv
package eot_pkg;

  // Default table depth
  localparam int unsigned TableSlotsDef = 32;

  // Field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned KeyW    = 12;
  localparam int unsigned LifeW   = 16;
  localparam int unsigned OwnerW  = 6;
  localparam int unsigned KindW   = 8;
  localparam int unsigned SlotOutW = 5;

  // Request codes
  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [TimeW-1:0]  expiry;
    logic [KeyW-1:0]   key;
    logic [OwnerW-1:0] owner;
    logic [KindW-1:0]  kind;
  } eot_entry_t;

endpackage

FILE: src/eot_entry_ram.sv
module eot_entry_ram #(
  parameter int unsigned DEPTH = eot_pkg::TableSlotsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  eot_pkg::eot_entry_t      wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output eot_pkg::eot_entry_t      rdata_o
);
  import eot_pkg::*;

  eot_entry_t mem_q [DEPTH];
  eot_entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/expiring_owner_table.sv
// Expiring owner table. A request (insert, lookup or clear) is taken when start is high and
// busy is low; its one result appears on the result ports for a single cycle with done_o high
// and cannot be held off, so the receiver must take it in that cycle. Entry data lives in a
// single-port-read synchronous RAM that is walked one slot per cycle. An insert scans up to
// the first inactive or expired slot (slot 0 when none is), a lookup scans the slots below
// the high-water count; in every case the result strobe shows in the first
// cycle with busy low. Clear and unused codes never raise busy; their result comes the cycle
// after accept.
// Active bits sit in flip-flops and reset clears them at once, so no clearing pass is needed.
module expiring_owner_table #(
  parameter int unsigned TABLE_SLOTS = eot_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [eot_pkg::ModeW-1:0]     mode_i,
  input  logic [eot_pkg::TimeW-1:0]     now_i,
  input  logic [eot_pkg::KeyW-1:0]      key_i,
  input  logic [eot_pkg::LifeW-1:0]     lifetime_i,
  input  logic [eot_pkg::OwnerW-1:0]    owner_i,
  input  logic [eot_pkg::KindW-1:0]     kind_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [eot_pkg::OwnerW-1:0]    found_owner_o,
  output logic [eot_pkg::KindW-1:0]     found_kind_o,
  output logic [eot_pkg::SlotOutW-1:0]  slot_o
);
  import eot_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_SLOTS);
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  // Control state
  state_e                 st_q, st_d;
  logic [TABLE_SLOTS-1:0] active_q, active_d;
  logic [CntW-1:0]        hw_q, hw_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        limit_q, limit_d;
  logic                   rd_vld_q, rd_vld_d;
  logic                   done_q, done_d;
  logic                   found_q, found_d;

  // Request and scan payload
  logic [ModeW-1:0]    mode_q, mode_d;
  logic [TimeW-1:0]    now_q, now_d;
  eot_entry_t          new_q, new_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     sel_q, sel_d;
  logic                lk_found_q, lk_found_d;
  logic [OwnerW-1:0]   lk_owner_q, lk_owner_d;
  logic [KindW-1:0]    lk_kind_q, lk_kind_d;
  logic [TimeW-1:0]    best_q, best_d;
  logic [OwnerW-1:0]   owner_q, owner_d;
  logic [KindW-1:0]    kind_q, kind_d;
  logic [SlotOutW-1:0] slot_q, slot_d;

  // RAM side
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  eot_entry_t      ram_rdata;

  logic            accept;
  logic [TimeW:0]  sum;
  logic            last;
  logic            ev;
  logic            ev_act;
  logic            ev_exp;

  assign accept = start && !busy;
  assign busy   = (st_q != ST_IDLE);

  // Saturating expiry for an insert
  assign sum = {1'b0, now_i} + (TimeW + 1)'(lifetime_i);

  // Scan bookkeeping
  assign last      = (cnt_q == limit_q);
  assign ram_re    = (st_q == ST_SCAN) && !last;
  assign ram_raddr = cnt_q[IdxW-1:0];
  assign ev        = (st_q == ST_SCAN) && rd_vld_q;
  assign ev_act    = active_q[rd_idx_q];
  assign ev_exp    = (ram_rdata.expiry <= now_q);
  assign ram_we    = (st_q == ST_WRITE);

  // Sequencer
  always_comb begin
    st_d       = st_q;
    active_d   = active_q;
    hw_d       = hw_q;
    cnt_d      = cnt_q;
    limit_d    = limit_q;
    rd_vld_d   = ram_re;
    rd_idx_d   = ram_raddr;
    done_d     = 1'b0;
    found_d    = 1'b0;
    owner_d    = '0;
    kind_d     = '0;
    slot_d     = '0;
    mode_d     = mode_q;
    now_d      = now_q;
    new_d      = new_q;
    sel_d      = sel_q;
    lk_found_d = lk_found_q;
    lk_owner_d = lk_owner_q;
    lk_kind_d  = lk_kind_q;
    best_d     = best_q;

    if (ram_re) begin
      cnt_d = cnt_q + CntW'(1);
    end

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d        = mode_i;
          now_d         = now_i;
          new_d.expiry  = sum[TimeW] ? '1 : sum[TimeW-1:0];
          new_d.key     = key_i;
          new_d.owner   = owner_i;
          new_d.kind    = kind_i;
          cnt_d         = '0;
          lk_found_d    = 1'b0;
          lk_owner_d    = '0;
          lk_kind_d     = '0;
          best_d        = '0;
          case (mode_i)
            MODE_INSERT: begin
              limit_d = CntW'(TABLE_SLOTS);
              st_d    = ST_SCAN;
            end
            MODE_LOOKUP: begin
              limit_d = hw_q;
              st_d    = ST_SCAN;
            end
            MODE_CLEAR: begin
              active_d = '0;
              hw_d     = '0;
              done_d   = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (mode_q == MODE_INSERT) begin
          // First inactive or expired slot, else slot 0
          if (ev && (!ev_act || ev_exp)) begin
            sel_d = rd_idx_q;
            st_d  = ST_WRITE;
          end else if (last) begin
            sel_d = '0;
            st_d  = ST_WRITE;
          end
        end else begin
          // Age out expired entries, keep the latest-expiring match
          if (ev && ev_act) begin
            if (ev_exp) begin
              active_d[rd_idx_q] = 1'b0;
            end else if (ram_rdata.key == new_q.key) begin
              lk_found_d = 1'b1;
              if (ram_rdata.expiry > best_q) begin
                best_d     = ram_rdata.expiry;
                lk_owner_d = ram_rdata.owner;
                lk_kind_d  = ram_rdata.kind;
              end
            end
          end
          if (last) begin
            done_d  = 1'b1;
            found_d = lk_found_d;
            owner_d = lk_owner_d;
            kind_d  = lk_kind_d;
            st_d    = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        active_d[sel_q] = 1'b1;
        if (CntW'(sel_q) >= hw_q) begin
          hw_d = CntW'(sel_q) + CntW'(1);
        end
        done_d = 1'b1;
        slot_d = SlotOutW'(sel_q);
        st_d   = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      active_q <= '0;
      hw_q     <= '0;
      cnt_q    <= '0;
      limit_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      active_q <= active_d;
      hw_q     <= hw_d;
      cnt_q    <= cnt_d;
      limit_q  <= limit_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
      found_q  <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    now_q      <= now_d;
    new_q      <= new_d;
    rd_idx_q   <= rd_idx_d;
    sel_q      <= sel_d;
    lk_found_q <= lk_found_d;
    lk_owner_q <= lk_owner_d;
    lk_kind_q  <= lk_kind_d;
    best_q     <= best_d;
    owner_q    <= owner_d;
    kind_q     <= kind_d;
    slot_q     <= slot_d;
  end

  eot_entry_ram #(
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sel_q),
    .wdata_i (new_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign found_owner_o = owner_q;
  assign found_kind_o  = kind_q;
  assign slot_o        = slot_q;

`ifndef ASSERT_OFF
  // High-water count never passes the table depth
  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= CntW'(TABLE_SLOTS))
    else $error("high-water count beyond table depth");

  // Insert and lookup occupy the sequencer
  a_busy_after_scan_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_INSERT || mode_i == MODE_LOOKUP)) |=> busy)
    else $error("scan request did not raise busy");

  // The write cycle always produces the insert result next
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WRITE) |=> (done_o && !busy))
    else $error("insert write without result strobe");

  // Result strobe only while the sequencer is idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (st_q == ST_IDLE))
    else $error("result strobe during scan");

  // Found is only shown with a strobe and never alongside an insert slot
  a_found_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (done_o && (slot_o == '0)))
    else $error("found outside a lookup result");
`endif

endmodule
